[rtl/inversion_counter_macros.svh]
// ----------------------------------------------------------------------------
// Inversion counter assertion macros
// Shared concurrent assertion forms, clocked on clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef INVERSION_COUNTER_MACROS_SVH
`define INVERSION_COUNTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ic_pkg.sv]
// ----------------------------------------------------------------------------
// Inversion counter package
// Sizes, the key encoding and the token that travels down the cell chain.
// ----------------------------------------------------------------------------
package ic_pkg;

    // Capacity of the chain, one stored value per cell.
    localparam int MAX_ELEMENTS = 1024;

    // Field widths on the ports.
    localparam int VALUE_W    = 32;
    localparam int OUT_CNT_W  = 19;
    localparam int OUT_ELEM_W = 11;

    // Per-item count of greater values seen; can reach MAX_ELEMENTS for a dropped item.
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    // Element counter, at least as wide as the output field.
    localparam int ELEM_W = (CNT_W > OUT_ELEM_W) ? CNT_W : OUT_ELEM_W;

    // Running total, wide enough for every pair and one bit over the output field.
    localparam longint unsigned MAX_PAIRS =
        (longint'(MAX_ELEMENTS) * longint'(MAX_ELEMENTS - 1)) / 2;
    localparam int TOTAL_RAW = $clog2(MAX_PAIRS + 1);
    localparam int TOTAL_W   = (TOTAL_RAW > OUT_CNT_W) ? TOTAL_RAW : OUT_CNT_W + 1;

    // Flipping the sign bit turns signed order into unsigned order.
    localparam logic [VALUE_W-1:0] SIGN_FLIP = {1'b1, {(VALUE_W - 1){1'b0}}};

    // One item in flight along the chain.
    typedef struct packed {
        logic               vld;
        logic               lst;
        logic               stored;
        logic [CNT_W-1:0]   cnt;
        logic [VALUE_W-1:0] key;
    } ic_token_t;

endpackage

[rtl/inversion_counter.sv]
// ----------------------------------------------------------------------------
// Inversion counter
// The result of a sequence appears once its last item has walked the cell
// chain and been taken into the result register in the tail.
// Throughput: one item per cycle; the chain only holds while a result waits.
// Reset clears every cell's occupancy, the totals and the result valid flag at once.
// ----------------------------------------------------------------------------
module inversion_counter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic signed [ic_pkg::VALUE_W-1:0] value,
    input  logic                          last,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [ic_pkg::OUT_CNT_W-1:0]  inversion_count,
    output logic [ic_pkg::OUT_ELEM_W-1:0] element_count,
    output logic                          too_long
);
    import ic_pkg::*;

`include "inversion_counter_macros.svh"

    ic_token_t tok [0:MAX_ELEMENTS];
    logic      advance;
    logic      last_out;

    // Items enter the chain as order keys with an empty count.
    always_comb
    begin
        tok[0].vld    = item_valid;
        tok[0].lst    = last;
        tok[0].stored = 1'b0;
        tok[0].cnt    = '0;
        tok[0].key    = value ^ SIGN_FLIP;
    end

    assign item_stall = !advance;

    // Chain of storage cells.
    for (genvar i = 0; i < MAX_ELEMENTS; i++)
    begin : g_cell
        ic_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    // Accumulation and result register.
    ic_tail u_tail (
        .clk             (clk),
        .rst_n           (rst_n),
        .tok_in          (tok[MAX_ELEMENTS]),
        .advance         (advance),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .inversion_count (inversion_count),
        .element_count   (element_count),
        .too_long        (too_long)
    );

    // A finished sequence is leaving the chain.
    assign last_out = tok[MAX_ELEMENTS].vld && tok[MAX_ELEMENTS].lst;

    // Input only stalls behind a stalled result with a finished sequence waiting.
    `IC_ASSERT_IMPL(a_stall_cause, item_stall,
                    result_valid && result_stall && last_out,
                    "input stalled without a blocked result")
    // A new result follows only from a last item leaving the chain.
    `IC_ASSERT_NEXT(a_emit_source, !last_out && !(result_valid && result_stall),
                    !result_valid,
                    "result raised without a last item")
    // A dropped item never counts more than MAX_ELEMENTS greater values.
    `IC_ASSERT_IMPL(a_drop_full, tok[MAX_ELEMENTS].vld && !tok[MAX_ELEMENTS].stored,
                    tok[MAX_ELEMENTS].cnt <= CNT_W'(MAX_ELEMENTS),
                    "dropped item count out of range")

endmodule

[rtl/ic_cell.sv]
// ----------------------------------------------------------------------------
// Inversion counter cell
// Holds one stored key, compares the passing item against it, stores an
// unstored item if the cell is free, and forwards the item to the next cell.
// ----------------------------------------------------------------------------
module ic_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  ic_pkg::ic_token_t tok_in,
    output ic_pkg::ic_token_t tok_out
);
    import ic_pkg::*;

    logic               occ_reg;
    logic               occ_next;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic               vld_reg;
    logic               lst_reg;
    logic               stored_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [VALUE_W-1:0] key_reg;
    ic_token_t          tok_next;
    logic               greater;
    logic               store_here;

    // Compare against the stored key and decide whether the item lands here.
    always_comb
    begin
        greater    = tok_in.vld && occ_reg && (value_reg > tok_in.key);
        store_here = tok_in.vld && !tok_in.stored && !occ_reg;

        tok_next        = tok_in;
        tok_next.cnt    = tok_in.cnt + CNT_W'(greater);
        tok_next.stored = tok_in.stored || store_here;

        // The last item of a sequence empties each cell behind it.
        occ_next   = occ_reg;
        value_next = value_reg;
        if (tok_in.vld)
        begin
            if (tok_in.lst)
            begin
                occ_next = 1'b0;
            end
            else if (store_here)
            begin
                occ_next = 1'b1;
            end
        end
        if (store_here)
        begin
            value_next = tok_in.key;
        end
    end

    // Control state: occupancy and the forwarded valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
            vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            occ_reg <= occ_next;
            vld_reg <= tok_next.vld;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            value_reg  <= value_next;
            lst_reg    <= tok_next.lst;
            stored_reg <= tok_next.stored;
            cnt_reg    <= tok_next.cnt;
            key_reg    <= tok_next.key;
        end
    end

    assign tok_out = {vld_reg, lst_reg, stored_reg, cnt_reg, key_reg};

endmodule

[rtl/ic_tail.sv]
// ----------------------------------------------------------------------------
// Inversion counter tail
// Accumulates the totals of items leaving the chain and holds the result
// register for the output channel; also decides when the chain advances.
// ----------------------------------------------------------------------------
module ic_tail (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ic_pkg::ic_token_t             tok_in,
    output logic                          advance,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [ic_pkg::OUT_CNT_W-1:0]  inversion_count,
    output logic [ic_pkg::OUT_ELEM_W-1:0] element_count,
    output logic                          too_long
);
    import ic_pkg::*;

    logic [TOTAL_W-1:0]    total_reg;
    logic [TOTAL_W-1:0]    total_next;
    logic [ELEM_W-1:0]     elem_reg;
    logic [ELEM_W-1:0]     elem_next;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic [TOTAL_W-1:0]    total_upd;
    logic [ELEM_W-1:0]     elem_upd;
    logic                  ovf_upd;
    logic                  emit;
    logic                  out_vld_reg;
    logic                  out_vld_next;
    logic [OUT_CNT_W-1:0]  out_cnt_reg;
    logic [OUT_CNT_W-1:0]  out_cnt_next;
    logic [OUT_ELEM_W-1:0] out_elem_reg;
    logic [OUT_ELEM_W-1:0] out_elem_next;
    logic                  out_long_reg;
    logic                  out_long_next;

    // Hold the chain only when a finished sequence cannot reach the result register.
    assign advance = !(tok_in.vld && tok_in.lst && out_vld_reg && result_stall);
    assign emit    = advance && tok_in.vld && tok_in.lst;

    // Fold the leaving item into the totals and build the result.
    always_comb
    begin
        total_upd = total_reg;
        elem_upd  = elem_reg;
        ovf_upd   = ovf_reg;
        if (tok_in.vld)
        begin
            if (tok_in.stored)
            begin
                total_upd = total_reg + TOTAL_W'(tok_in.cnt);
                elem_upd  = elem_reg + ELEM_W'(1);
            end
            else
            begin
                ovf_upd = 1'b1;
            end
        end

        total_next = total_reg;
        elem_next  = elem_reg;
        ovf_next   = ovf_reg;
        if (advance && tok_in.vld)
        begin
            if (tok_in.lst)
            begin
                total_next = '0;
                elem_next  = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                total_next = total_upd;
                elem_next  = elem_upd;
                ovf_next   = ovf_upd;
            end
        end

        // Saturate the total to the output field.
        if (|total_upd[TOTAL_W-1:OUT_CNT_W])
        begin
            out_cnt_next = '1;
        end
        else
        begin
            out_cnt_next = total_upd[OUT_CNT_W-1:0];
        end
        out_elem_next = elem_upd[OUT_ELEM_W-1:0];
        out_long_next = ovf_upd;

        if (emit)
        begin
            out_vld_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= '0;
            elem_reg    <= '0;
            ovf_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            total_reg   <= total_next;
            elem_reg    <= elem_next;
            ovf_reg     <= ovf_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Result payload, loaded on each emitted transfer.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_cnt_reg  <= out_cnt_next;
            out_elem_reg <= out_elem_next;
            out_long_reg <= out_long_next;
        end
    end

    assign result_valid    = out_vld_reg;
    assign inversion_count = out_cnt_reg;
    assign element_count   = out_elem_reg;
    assign too_long        = out_long_reg;

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// Inversion counter testbench
// Feeds signed sequences through the valid/stall item port and checks every
// sequence summary against a built-in predictor. A short directed part covers
// the value extremes, equal values and mixed signs. A random part follows with
// many short sequences and one sequence that fills the chain, holds the most
// inversions and overruns capacity with DROPPED_TAIL random values. Both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ic_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = MAX_ELEMENTS + 80;
    localparam int RANDOM_ITEMS   = 1950;
    localparam int MAX_GAP        = 12;
    localparam int DROPPED_TAIL   = 3;
    localparam int DESCENT_STEP   = 4194303;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W - 1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W - 1){1'b1}}};
    localparam longint unsigned COUNT_SAT = (64'd1 << OUT_CNT_W) - 1;

    // Value styles for random sequences.
    typedef enum int { STYLE_FULL, STYLE_NARROW, STYLE_EXTREME } value_style_t;

    typedef logic signed [VALUE_W-1:0] value_q_t [$];

    // What one sequence should report when its last item is taken.
    typedef struct packed {
        logic [OUT_CNT_W-1:0]  inversions;
        logic [OUT_ELEM_W-1:0] elements;
        logic                  dropped;
    } seq_summary_t;

    // Predicts sequence summaries and compares them with what the block reports.
    class inversion_tracker;
        logic signed [VALUE_W-1:0] kept [MAX_ELEMENTS];
        int unsigned               kept_count;
        longint unsigned           pair_total;
        bit                        overflow;
        seq_summary_t              pending_summaries [$];
        int unsigned               mismatches;

        function new();
            kept_count = 0;
            pair_total = 0;
            overflow   = 1'b0;
            mismatches = 0;
        endfunction

        // Counts how many kept values exceed the new one, then keeps it if room.
        function void take_value(logic signed [VALUE_W-1:0] v, logic lst);
            int unsigned  greater;
            seq_summary_t s;
            if (kept_count < MAX_ELEMENTS)
            begin
                greater = 0;
                for (int i = 0; i < kept_count; i++)
                begin
                    if (kept[i] > v)
                        greater++;
                end
                pair_total += greater;
                kept[kept_count] = v;
                kept_count++;
            end
            else
            begin
                overflow = 1'b1;
            end

            if (lst)
            begin
                s.inversions = (pair_total > COUNT_SAT) ? OUT_CNT_W'(COUNT_SAT)
                                                        : OUT_CNT_W'(pair_total);
                s.elements   = OUT_ELEM_W'(kept_count);
                s.dropped    = overflow;
                pending_summaries = {pending_summaries, s};
                kept_count = 0;
                pair_total = 0;
                overflow   = 1'b0;
            end
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
            mismatches++;
        endtask

        // Compares one reported summary with the oldest prediction.
        task check_summary(logic [OUT_CNT_W-1:0] inv, logic [OUT_ELEM_W-1:0] elem, logic tl);
            seq_summary_t want;
            if (pending_summaries.size() == 0)
            begin
                report_mismatch("unexpected result, inversion_count", inv, -1);
            end
            else
            begin
                want = pending_summaries.pop_front();
                if (inv !== want.inversions)
                    report_mismatch("inversion_count", inv, want.inversions);
                if (elem !== want.elements)
                    report_mismatch("element_count", elem, want.elements);
                if (tl !== want.dropped)
                    report_mismatch("too_long", tl, want.dropped);
            end
        endtask
    endclass

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      item_valid   = 1'b0;
    logic                      item_stall;
    logic signed [VALUE_W-1:0] value        = '0;
    logic                      last         = 1'b0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    logic [OUT_CNT_W-1:0]      inversion_count;
    logic [OUT_ELEM_W-1:0]     element_count;
    logic                      too_long;

    inversion_tracker tracker = new();
    int unsigned      items_sent = 0;
    int unsigned      idle_cycles = 0;
    bit               tx_calm = 1'b0;
    bit               rx_calm = 1'b0;

    inversion_counter dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .value           (value),
        .last            (last),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .inversion_count (inversion_count),
        .element_count   (element_count),
        .too_long        (too_long)
    );

    // Free-running clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Presents one item after a random gap, none while calm, and waits for its transfer.
    task automatic send_value(input logic signed [VALUE_W-1:0] v, input logic lst);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        value      <= v;
        last       <= lst;
        do @(posedge clk); while (item_stall);
        tracker.take_value(v, lst);
        items_sent++;
    endtask

    task automatic send_sequence(input value_q_t vals);
        for (int i = 0; i < vals.size(); i++)
            send_value(vals[i], i == vals.size() - 1);
    endtask

    // Holds off the sender until every predicted summary has come back.
    task automatic drain_results();
        item_valid <= 1'b0;
        do @(posedge clk); while (tracker.pending_summaries.size() != 0);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value(value_style_t style);
        logic signed [VALUE_W-1:0] v;
        case (style)
            STYLE_NARROW:  v = $signed($urandom_range(0, 8)) - 4;
            STYLE_EXTREME:
                case ($urandom_range(0, 6))
                    0:       v = VAL_MIN;
                    1:       v = VAL_MIN + 1;
                    2:       v = -1;
                    3:       v = 0;
                    4:       v = 1;
                    5:       v = VAL_MAX - 1;
                    default: v = VAL_MAX;
                endcase
            default:       v = $urandom;
        endcase
        return v;
    endfunction

    // Result side: unless calm, stalls for a random number of cycles, then takes one transfer.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 7) == 0)
                rx_calm = ~rx_calm;
            n = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
            result_stall <= (n != 0);
            repeat (n) @(posedge clk);
            if (n != 0)
                result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
            tracker.check_summary(inversion_count, element_count, too_long);
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Main stimulus.
    initial
    begin
        value_q_t     seq;
        value_style_t style;
        int           len;
        bit           long_done;
        logic signed [VALUE_W-1:0] v;

        long_done = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single item, extremes both ways, equal values, mixed signs.
        send_sequence('{0});
        send_sequence('{VAL_MAX, VAL_MIN});
        send_sequence('{VAL_MIN, VAL_MAX});
        send_sequence('{5, 5, 5});
        send_sequence('{1, -1, 0, -1});
        send_sequence('{3, 2, 1, 0, -1, -2});
        send_sequence('{VAL_MIN, -1, 0, VAL_MAX, VAL_MAX});
        drain_results();

        // Random sequences, with one full-capacity overrun part way through.
        while (items_sent < RANDOM_ITEMS + 23)
        begin
            tx_calm = ($urandom_range(0, 3) == 0);
            seq.delete();
            if (!long_done && items_sent > 500)
            begin
                // Strictly descending fill gives the largest possible count;
                // the tail of random values then lands on a full store.
                v = VAL_MAX;
                for (int i = 0; i < MAX_ELEMENTS; i++)
                begin
                    seq = {seq, v};
                    v = v - $urandom_range(1, DESCENT_STEP);
                end
                for (int i = 0; i < DROPPED_TAIL; i++)
                    seq = {seq, pick_value(STYLE_FULL)};
                long_done = 1'b1;
            end
            else
            begin
                style = value_style_t'($urandom_range(0, 2));
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                                  : $urandom_range(1, 40);
                for (int i = 0; i < len; i++)
                    seq = {seq, pick_value(style)};
            end
            send_sequence(seq);
            if ($urandom_range(0, 24) == 0)
                drain_results();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_summaries.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[inversion_counter.f]
+incdir+rtl
rtl/ic_pkg.sv
rtl/ic_cell.sv
rtl/ic_tail.sv
rtl/inversion_counter.sv
verif/tb_top.sv
